@@ rtl/core/bch_pkg.sv @@
// Shared constants and types for the BCH systematic encoder.
package bch_pkg;

    localparam int MAX_PARITY = 192;   // longest parity register
    localparam int WORD_W     = 64;    // parity word width
    localparam int CNT_W      = 7;     // width of out_count
    localparam int LEN_W      = 16;    // msg_len width
    localparam int PLEN_W     = 8;     // parity length width
    localparam int ADDR_W     = 3;     // config register index width

    // Config register indexes
    localparam logic [ADDR_W-1:0] REG_MSG_LEN    = 3'd0;
    localparam logic [ADDR_W-1:0] REG_PAR_LEN    = 3'd1;
    localparam logic [ADDR_W-1:0] REG_GEN_WORD0  = 3'd2;
    localparam logic [ADDR_W-1:0] REG_GEN_WORD1  = 3'd3;
    localparam logic [ADDR_W-1:0] REG_GEN_WORD2  = 3'd4;

    // Control broadcast from the sequencer to every cell
    typedef struct packed {
        logic step;   // message bit: divide by g(x)
        logic flush;  // parity word taken: move up by one word
        logic fb;     // feedback bit
    } t_cell_ctl;

    // One result item
    typedef struct packed {
        logic [WORD_W-1:0] out_data;
        logic [CNT_W-1:0]  out_count;
        logic              is_parity;
        logic              last;
    } t_result;

endpackage

@@ rtl/core/bch_if.sv @@
// Stream and configuration channel interfaces of the BCH encoder.
interface bch_in_if;
    logic valid;
    logic ready;
    logic msg_bit;

    modport source (output valid, output msg_bit, input ready);
    modport sink   (input valid, input msg_bit, output ready);
endinterface

interface bch_out_if;
    logic                             valid;
    logic                             ready;
    logic [bch_pkg::WORD_W-1:0]       out_data;
    logic [bch_pkg::CNT_W-1:0]        out_count;
    logic                             is_parity;
    logic                             last;

    modport source (output valid, output out_data, output out_count,
                    output is_parity, output last, input ready);
    modport sink   (input valid, input out_data, input out_count,
                    input is_parity, input last, output ready);
endinterface

interface bch_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [bch_pkg::ADDR_W-1:0]  addr;
    logic [bch_pkg::WORD_W-1:0]  data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

@@ rtl/core/bch_cell.sv @@
// One stage of the parity shift register.
module bch_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bch_pkg::t_cell_ctl i_ctl,
    input  logic               i_en,    // position below effective parity length
    input  logic               i_gen,   // generator coefficient at this position
    input  logic               i_prev,  // neighbor one position down
    input  logic               i_far,   // neighbor one word down
    output logic               o_bit
);

    logic r_bit;
    logic n_bit;

    always_comb begin
        n_bit = r_bit;
        if (i_ctl.step) begin
            n_bit = i_en & (i_prev ^ (i_gen & i_ctl.fb));
        end else if (i_ctl.flush) begin
            n_bit = i_en & i_far;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= 1'b0;
        end else begin
            r_bit <= n_bit;
        end
    end

    assign o_bit = r_bit;

endmodule

@@ rtl/core/bch_chain.sv @@
// Row of parity cells plus the tap that reads them out top first.
module bch_chain #(
    parameter int MAX_PARITY = bch_pkg::MAX_PARITY
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bch_pkg::t_cell_ctl            i_ctl,
    input  logic [bch_pkg::PLEN_W-1:0]    i_plen,   // effective parity length
    input  logic [3*bch_pkg::WORD_W-1:0]  i_gen,
    output logic [bch_pkg::WORD_W-1:0]    o_word    // bit 0 is the top register bit
);

    localparam int IW = (MAX_PARITY > 1) ? $clog2(MAX_PARITY) : 1;
    localparam int WW = bch_pkg::WORD_W;

    logic [MAX_PARITY-1:0] cell_q;

    for (genvar j = 0; j < MAX_PARITY; j++) begin : g_cell
        logic prev_bit;
        logic far_bit;

        if (j == 0) begin : g_bot
            assign prev_bit = 1'b0;
        end else begin : g_mid
            assign prev_bit = cell_q[j-1];
        end

        if (j < WW) begin : g_nofar
            assign far_bit = 1'b0;
        end else begin : g_far
            assign far_bit = cell_q[j-WW];
        end

        bch_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (i_ctl),
            .i_en    (bch_pkg::PLEN_W'(j) < i_plen),
            .i_gen   (i_gen[j]),
            .i_prev  (prev_bit),
            .i_far   (far_bit),
            .o_bit   (cell_q[j])
        );
    end

    // word bit b reads position plen-1-b; positions below zero read as 0
    for (genvar b = 0; b < WW; b++) begin : g_tap
        logic [bch_pkg::PLEN_W:0] pos;
        assign pos = {1'b0, i_plen} - (bch_pkg::PLEN_W+1)'(b + 1);
        assign o_word[b] = (!pos[bch_pkg::PLEN_W] &&
                            (pos < (bch_pkg::PLEN_W+1)'(MAX_PARITY)))
                           ? cell_q[pos[IW-1:0]] : 1'b0;
    end

endmodule

@@ rtl/core/bch_systematic_lfsr_encoder.sv @@
// Top level of the bit-serial systematic BCH encoder.
//
// Usage:
//  - i_msg carries one message bit per item. Each accepted bit is echoed as
//    a result item (out_data bit 0, out_count 1, is_parity 0, last 0).
//  - After msg_len bits the parity follows as ceil(P/64) words, P being the
//    effective parity length; the top register bit is word bit 0, and the
//    final word has last set. The register and bit counter then clear.
//  - i_cfg writes msg_len, the parity length and gen_word0..2 by index; it
//    is always ready. Write only while the block is idle.
//  - Output timing: the echo is registered on its way to o_res; the parity
//    words follow right behind it, one per cycle while the skid register is empty.
//  - Throughput: one message bit per cycle while the skid register is empty;
//    at a codeword end the input stalls while the parity words leave the chain.
//  - Output stall: results go through an output register and a skid
//    register; the input is held off once the skid register is full.
//  - Reset (i_rst_n low, synchronous) clears the chain, counter and config
//    to msg_len 1, parity length 192, g(x) = 1, and empties the output.
module bch_systematic_lfsr_encoder #(
    parameter int MAX_PARITY = bch_pkg::MAX_PARITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bch_in_if.sink      i_msg,
    bch_cfg_if.sink     i_cfg,
    bch_out_if.source   o_res
);

    localparam int WW = bch_pkg::WORD_W;
    localparam int PW = bch_pkg::PLEN_W;
    localparam int LW = bch_pkg::LEN_W;

    // configuration
    logic [LW-1:0]   r_msg_len;
    logic [PW-1:0]   r_par_len;
    logic [3*WW-1:0] r_gen;

    // sequencer
    logic [LW-1:0] r_cnt, n_cnt;
    logic          r_flush, n_flush;     // parity words still to emit
    logic [PW-1:0] r_remain, n_remain;   // parity bits not yet emitted

    // output register and skid register
    bch_pkg::t_result r_out, n_out, r_skd, n_skd;
    logic             r_out_v, n_out_v, r_skd_v, n_skd_v;

    logic [PW-1:0]     plen;
    logic [LW-1:0]     len_eff;
    logic [LW-1:0]     cnt_inc;
    logic              cw_end;
    logic              prod_rdy, acc, fl, pop, prod_v;
    logic [WW-1:0]     word;
    bch_pkg::t_result  prod;
    bch_pkg::t_cell_ctl ctl;

    // effective parity length: zero reads as one, clamp to register size
    always_comb begin
        if (r_par_len == '0) begin
            plen = PW'(1);
        end else if (r_par_len > PW'(MAX_PARITY)) begin
            plen = PW'(MAX_PARITY);
        end else begin
            plen = r_par_len;
        end
    end

    assign len_eff = (r_msg_len == '0) ? LW'(1) : r_msg_len;
    assign cnt_inc = r_cnt + LW'(1);
    assign cw_end  = (cnt_inc >= len_eff) || (cnt_inc == '0);

    // producer side only waits on the skid register
    assign prod_rdy    = !r_skd_v;
    assign i_msg.ready = prod_rdy && !r_flush;
    assign acc         = i_msg.valid && i_msg.ready;
    assign fl          = r_flush && prod_rdy;

    // word bit 0 is the top register bit, which is also the feedback tap
    assign ctl.step  = acc;
    assign ctl.flush = fl;
    assign ctl.fb    = i_msg.msg_bit ^ word[0];

    bch_chain #(
        .MAX_PARITY (MAX_PARITY)
    ) u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_plen  (plen),
        .i_gen   (r_gen),
        .o_word  (word)
    );

    // result produced this cycle: echo or parity word
    always_comb begin
        prod_v = acc || fl;
        if (acc) begin
            prod.out_data  = {{(WW-1){1'b0}}, i_msg.msg_bit};
            prod.out_count = bch_pkg::CNT_W'(1);
            prod.is_parity = 1'b0;
            prod.last      = 1'b0;
        end else begin
            prod.out_data  = word;
            prod.out_count = (r_remain >= PW'(WW)) ? bch_pkg::CNT_W'(WW)
                                                   : r_remain[bch_pkg::CNT_W-1:0];
            prod.is_parity = 1'b1;
            prod.last      = (r_remain <= PW'(WW));
        end
    end

    // codeword sequencing
    always_comb begin
        n_cnt    = r_cnt;
        n_flush  = r_flush;
        n_remain = r_remain;
        if (acc) begin
            if (cw_end) begin
                n_cnt    = '0;
                n_flush  = 1'b1;
                n_remain = plen;
            end else begin
                n_cnt = cnt_inc;
            end
        end else if (fl) begin
            n_remain = r_remain - PW'(WW);
            if (r_remain <= PW'(WW)) begin
                n_flush = 1'b0;
            end
        end
    end

    // output register with skid
    assign pop = r_out_v && o_res.ready;

    always_comb begin
        n_out_v = r_out_v;
        n_out   = r_out;
        n_skd_v = r_skd_v;
        n_skd   = r_skd;
        if (r_skd_v) begin
            if (pop) begin
                n_out   = r_skd;
                n_skd_v = 1'b0;
            end
        end else if (!r_out_v || pop) begin
            n_out_v = prod_v;
            n_out   = prod;
        end else if (prod_v) begin
            n_skd_v = 1'b1;
            n_skd   = prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_flush  <= 1'b0;
            r_remain <= '0;
            r_out_v  <= 1'b0;
            r_skd_v  <= 1'b0;
        end else begin
            r_cnt    <= n_cnt;
            r_flush  <= n_flush;
            r_remain <= n_remain;
            r_out_v  <= n_out_v;
            r_skd_v  <= n_skd_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_skd <= n_skd;
    end

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msg_len <= LW'(1);
            r_par_len <= PW'(192);
            r_gen     <= {{(2*WW){1'b0}}, WW'(1)};
        end else if (i_cfg.valid) begin
            unique case (i_cfg.addr)
                bch_pkg::REG_MSG_LEN:    r_msg_len          <= i_cfg.data[LW-1:0];
                bch_pkg::REG_PAR_LEN:    r_par_len          <= i_cfg.data[PW-1:0];
                bch_pkg::REG_GEN_WORD0:  r_gen[WW-1:0]      <= i_cfg.data;
                bch_pkg::REG_GEN_WORD1:  r_gen[2*WW-1:WW]   <= i_cfg.data;
                bch_pkg::REG_GEN_WORD2:  r_gen[3*WW-1:2*WW] <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign o_res.valid     = r_out_v;
    assign o_res.out_data  = r_out.out_data;
    assign o_res.out_count = r_out.out_count;
    assign o_res.is_parity = r_out.is_parity;
    assign o_res.last      = r_out.last;

endmodule

@@ verif/bch_checker.sv @@
// Scoreboard for the BCH encoder: bit-true mirror of the parity divider plus in-order result checks.
module bch_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    bch_in_if    msg_mon,
    bch_cfg_if   cfg_mon,
    bch_out_if   res_mon,
    output int   o_fail_cnt,
    output int   o_pending,
    output int   o_checked,
    output int   o_codewords
);
    import bch_pkg::*;

    // mirrored register file
    logic [LEN_W-1:0]      msg_len_q;
    logic [PLEN_W-1:0]     par_len_q;
    logic [MAX_PARITY-1:0] gen_taps;

    // mirrored datapath state
    logic [MAX_PARITY-1:0] lfsr_q;
    logic [LEN_W-1:0]      bit_cnt_q;

    t_result expected_q[$];
    int      fails = 0;
    int      checked = 0;
    int      codewords = 0;

    // One message bit: echo it, clock the divider, and at codeword end queue the parity words.
    task automatic encode_bit(input logic b);
        int unsigned           deg;
        int unsigned           base;
        int unsigned           n;
        int unsigned           k;
        logic                  fb;
        logic [LEN_W-1:0]      len;
        logic [MAX_PARITY-1:0] keep;
        t_result               word;

        // zero degree acts as 1, anything past the register saturates
        if (par_len_q == 0)
            deg = 1;
        else if (par_len_q > MAX_PARITY)
            deg = MAX_PARITY;
        else
            deg = par_len_q;

        fb   = b ^ lfsr_q[deg-1];
        keep = (deg >= MAX_PARITY) ? '1 : ((MAX_PARITY'(1) << deg) - 1'b1);
        // coefficients at or above the degree are dropped by the mask
        lfsr_q = ((lfsr_q << 1) ^ (fb ? gen_taps : '0)) & keep;

        word = '0;
        word.out_data[0] = b;
        word.out_count   = CNT_W'(1);
        expected_q.push_back(word);

        len       = (msg_len_q == 0) ? LEN_W'(1) : msg_len_q;
        bit_cnt_q = bit_cnt_q + 1'b1;

        if (bit_cnt_q >= len || bit_cnt_q == 0) begin
            for (base = 0; base < deg; base += WORD_W) begin
                n    = (deg - base > WORD_W) ? WORD_W : deg - base;
                word = '0;
                // top register bit leaves first, in word bit 0
                for (k = 0; k < n; k++)
                    word.out_data[k] = lfsr_q[deg-1-base-k];
                word.out_count = CNT_W'(n);
                word.is_parity = 1'b1;
                word.last      = (base + n >= deg);
                expected_q.push_back(word);
            end
            lfsr_q    = '0;
            bit_cnt_q = '0;
        end
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_result want;

        if (!i_rst_n) begin
            msg_len_q = LEN_W'(1);
            par_len_q = PLEN_W'(MAX_PARITY);
            gen_taps  = MAX_PARITY'(1);
            lfsr_q    = '0;
            bit_cnt_q = '0;
            expected_q.delete();
        end else begin
            // results are registered, so they leave after their cause; compare before predicting
            if (res_mon.valid && res_mon.ready) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected result item: out_data %h out_count %0d is_parity %0b last %0b",
                           res_mon.out_data, res_mon.out_count, res_mon.is_parity, res_mon.last);
                    fails++;
                end else begin
                    want = expected_q.pop_front();
                    checked++;
                    if (res_mon.out_data !== want.out_data) begin
                        $error("out_data: expected %h, got %h", want.out_data, res_mon.out_data);
                        fails++;
                    end
                    if (res_mon.out_count !== want.out_count) begin
                        $error("out_count: expected %0d, got %0d", want.out_count,
                               res_mon.out_count);
                        fails++;
                    end
                    if (res_mon.is_parity !== want.is_parity) begin
                        $error("is_parity: expected %0b, got %0b", want.is_parity,
                               res_mon.is_parity);
                        fails++;
                    end
                    if (res_mon.last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, res_mon.last);
                        fails++;
                    end
                    if (want.last)
                        codewords++;
                end
            end

            if (cfg_mon.valid && cfg_mon.ready) begin
                case (cfg_mon.addr)
                    REG_MSG_LEN:    msg_len_q              = cfg_mon.data[LEN_W-1:0];
                    REG_PAR_LEN:    par_len_q              = cfg_mon.data[PLEN_W-1:0];
                    REG_GEN_WORD0:  gen_taps[63:0]         = cfg_mon.data;
                    REG_GEN_WORD1:  gen_taps[127:64]       = cfg_mon.data;
                    REG_GEN_WORD2:  gen_taps[191:128]      = cfg_mon.data;
                    default: ;
                endcase
            end

            if (msg_mon.valid && msg_mon.ready)
                encode_bit(msg_mon.msg_bit);
        end

        o_fail_cnt  <= fails;
        o_pending   <= expected_q.size();
        o_checked   <= checked;
        o_codewords <= codewords;
    end

endmodule

@@ verif/tb_top.sv @@
// Testbench top for the BCH encoder: clock, reset, stimulus, output stalls and verdict.
module tb_top;
    import bch_pkg::*;

    localparam int TOTAL_ITEMS  = 150;   // random batches start until this many bits are sent
    localparam int HOLD_CYCLES  = 60;    // long output hold-off to back up the input
    localparam int QUIET_LIMIT  = 1000;  // cycles with no handshake anywhere before giving up
    localparam int END_WAIT     = 8;     // extra wait after the last drain to catch stray results

    // index with no register behind it: the write must be ignored
    localparam logic [ADDR_W-1:0] REG_SPARE = 3'd7;

    // output stall patterns
    typedef enum logic [1:0] {RX_FREE, RX_SPARSE, RX_CHOPPY} t_rx_mode;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] data;
    } t_reg_wr;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bch_in_if  msg_ch ();
    bch_cfg_if cfg_ch ();
    bch_out_if res_ch ();

    int fail_cnt;
    int pending;
    int checked;
    int codewords;

    int      bits_sent  = 0;
    int      burst_left = 0;
    int      reg_writes = 0;
    int      phases     = 0;
    int      hold_asks  = 0;   // bumped by the stimulus, served by the receiver process
    int      quiet_cycles = 0;
    t_reg_wr reg_wr_q[$];

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    bch_systematic_lfsr_encoder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_msg   (msg_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    bch_checker u_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .msg_mon     (msg_ch),
        .cfg_mon     (cfg_ch),
        .res_mon     (res_ch),
        .o_fail_cnt  (fail_cnt),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_codewords (codewords)
    );

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic queue_reg(input logic [ADDR_W-1:0] addr, input logic [WORD_W-1:0] data);
        reg_wr_q.push_back({addr, data});
    endtask

    // Pushes every queued register write back to back, then drops valid.
    // Only called once the output side has drained, i.e. with the block idle.
    task automatic write_regs();
        t_reg_wr wr;
        while (reg_wr_q.size() != 0) begin
            wr = reg_wr_q.pop_front();
            cfg_ch.valid <= 1'b1;
            cfg_ch.addr  <= wr.addr;
            cfg_ch.data  <= wr.data;
            // ready is sampled at the edge, before the block updates
            @(posedge i_clk iff cfg_ch.ready);
            reg_writes++;
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // Offers one message bit. The sender runs in bursts; when a burst runs out,
    // valid drops for a short random gap before the next burst starts.
    // Valid stays high after the handshake so bursts stream back to back.
    task automatic send_bit(input logic b);
        if (burst_left == 0) begin
            msg_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
        msg_ch.valid   <= 1'b1;
        msg_ch.msg_bit <= b;
        // ready is sampled at the edge, before the block updates
        @(posedge i_clk iff msg_ch.ready);
        burst_left--;
        bits_sent++;
    endtask

    // Stops offering and waits until the scoreboard holds no expectation.
    // The count it exports is registered, so look only after the next edge.
    task automatic drain();
        msg_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: switches between stall patterns, and on request holds
    // ready low for a long stretch so the skid buffer fills and the
    // encoder must push back on its input.
    // ------------------------------------------------------------------
    initial begin : receiver
        int       hold_left;
        int       mode_left;
        int       holds_served;
        t_rx_mode rx_mode;

        hold_left    = 0;
        mode_left    = 0;
        holds_served = 0;
        rx_mode      = RX_FREE;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                res_ch.ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else if (holds_served != hold_asks) begin
                holds_served++;
                hold_left = HOLD_CYCLES - 1;
                res_ch.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = t_rx_mode'($urandom_range(0, 2));
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (rx_mode)
                    RX_FREE:   res_ch.ready <= 1'b1;
                    RX_SPARSE: res_ch.ready <= ($urandom_range(0, 3) != 0);
                    default:   res_ch.ready <= ($urandom_range(0, 1) != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: any handshake resets it; a long silence means a hang.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((msg_ch.valid && msg_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
            $display("bch_systematic_lfsr_encoder: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [WORD_W-1:0] rnd;
        int unsigned       plen;
        int unsigned       mlen;
        int unsigned       n_phase;
        int unsigned       i;

        msg_ch.valid   <= 1'b0;
        msg_ch.msg_bit <= 1'b0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.addr    <= REG_MSG_LEN;
        cfg_ch.data    <= '0;
        i_rst_n        <= 1'b0;
        repeat (3)
            @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed ---

        // Reset settings: one-bit codewords, full 192-bit parity, g(x) = 1.
        // Every bit closes a codeword with three parity words.
        send_bit(1'b1);
        send_bit(1'b0);
        send_bit(1'b1);
        drain();

        // Degree zero acts as 1; all-ones low word checks that taps at or
        // above the degree are ignored. Upper data bits of msg_len must be
        // masked off. A write to the spare index must change nothing.
        queue_reg(REG_MSG_LEN,    64'hFFFF_FFFF_FFFF_0004);
        queue_reg(REG_PAR_LEN,    64'h0);
        queue_reg(REG_GEN_WORD0,  '1);
        queue_reg(REG_GEN_WORD1,  {$urandom, $urandom});
        queue_reg(REG_GEN_WORD2,  {$urandom, $urandom});
        queue_reg(REG_SPARE,      {$urandom, $urandom});
        write_regs();
        send_bit(1'b1);
        send_bit(1'b0);
        send_bit(1'b1);
        send_bit(1'b1);
        drain();

        // Degree above the register saturates to 192; msg_len zero acts as 1.
        queue_reg(REG_PAR_LEN,    64'd255);
        queue_reg(REG_MSG_LEN,    64'd0);
        queue_reg(REG_GEN_WORD0,  '1);
        queue_reg(REG_GEN_WORD1,  '1);
        queue_reg(REG_GEN_WORD2,  '1);
        write_regs();
        send_bit(1'b1);
        send_bit(1'b1);
        drain();

        // Exactly one parity word, then one bit past a word boundary.
        queue_reg(REG_PAR_LEN,    64'd64);
        queue_reg(REG_MSG_LEN,    64'd3);
        queue_reg(REG_GEN_WORD0,  {$urandom, $urandom} | 64'd1);
        write_regs();
        send_bit(1'b1);
        send_bit(1'b0);
        send_bit(1'b1);
        drain();
        queue_reg(REG_PAR_LEN,    64'd65);
        queue_reg(REG_GEN_WORD1,  {$urandom, $urandom});
        write_regs();
        send_bit(1'b0);
        send_bit(1'b1);
        send_bit(1'b1);
        drain();

        // msg_len lowered mid-codeword: the next bit already passes it.
        queue_reg(REG_MSG_LEN,    64'd16);
        queue_reg(REG_PAR_LEN,    64'd129);
        queue_reg(REG_GEN_WORD0,  {$urandom, $urandom});
        queue_reg(REG_GEN_WORD1,  {$urandom, $urandom});
        queue_reg(REG_GEN_WORD2,  {$urandom, $urandom});
        write_regs();
        repeat (5)
            send_bit(1'($urandom_range(0, 1)));
        drain();
        queue_reg(REG_MSG_LEN, 64'd2);
        write_regs();
        send_bit(1'b1);
        drain();

        // Longest codeword opened, degree cut mid-codeword (upper register
        // bits fall away), then closed early by lowering msg_len.
        queue_reg(REG_MSG_LEN,    64'd65535);
        queue_reg(REG_PAR_LEN,    64'd128);
        write_regs();
        repeat (3)
            send_bit(1'($urandom_range(0, 1)));
        drain();
        queue_reg(REG_PAR_LEN,    64'd40);
        write_regs();
        send_bit(1'b1);
        drain();
        queue_reg(REG_MSG_LEN, 64'd1);
        write_regs();
        send_bit(1'b0);
        drain();

        // --- random ---
        // Each setting gets a batch of random bits. Codewords often span
        // batches, so settings also change mid-codeword. The first batch
        // runs under a long output hold-off.
        n_phase = 0;
        while (bits_sent < TOTAL_ITEMS) begin
            // message length: mostly short codewords, sometimes zero or any 16-bit value
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: mlen = $urandom_range(1, 8);
                6, 7:             mlen = $urandom_range(9, 40);
                8:                mlen = 0;
                default:          mlen = $urandom_range(0, 65535);
            endcase
            // degree: anywhere, near the word boundaries, zero, or past the top
            case ($urandom_range(0, 7))
                0, 1, 2: plen = $urandom_range(1, MAX_PARITY);
                3, 4:    plen = 64 * $urandom_range(1, 3) + $urandom_range(0, 2) - 1;
                5:       plen = 0;
                6:       plen = $urandom_range(MAX_PARITY + 1, 255);
                default: plen = $urandom_range(1, 64);
            endcase

            if ($urandom_range(0, 1) != 0) begin
                rnd = {$urandom, $urandom};
                rnd[LEN_W-1:0] = mlen[LEN_W-1:0];
                queue_reg(REG_MSG_LEN, rnd);
            end
            if ($urandom_range(0, 1) != 0) begin
                rnd = {$urandom, $urandom};
                rnd[PLEN_W-1:0] = plen[PLEN_W-1:0];
                queue_reg(REG_PAR_LEN, rnd);
            end
            for (i = 0; i < 3; i++) begin
                if ($urandom_range(0, 1) != 0) begin
                    case ($urandom_range(0, 7))
                        0:       rnd = '0;
                        1:       rnd = '1;
                        default: rnd = {$urandom, $urandom};
                    endcase
                    queue_reg(REG_GEN_WORD0 + ADDR_W'(i), rnd);
                end
            end
            if ($urandom_range(0, 9) == 0)
                queue_reg(REG_SPARE, {$urandom, $urandom});
            if (reg_wr_q.size() == 0)
                queue_reg(REG_MSG_LEN, WORD_W'(mlen));
            write_regs();

            if (n_phase == 0) begin
                // keep offering bits while the receiver is held off
                hold_asks <= hold_asks + 1;
                n_phase = 30;
            end else begin
                n_phase = $urandom_range(6, 28);
            end
            repeat (n_phase)
                send_bit(1'($urandom_range(0, 1)));
            drain();
            phases++;
        end

        // everything expected has arrived; give strays a chance to show up
        repeat (END_WAIT)
            @(posedge i_clk);

        $display("covered %0d message bits over %0d random settings, %0d register writes",
                 bits_sent, phases, reg_writes);
        $display("checked %0d result items, %0d codewords closed by a last word",
                 checked, codewords);
        if (fail_cnt == 0 && pending == 0)
            $display("bch_systematic_lfsr_encoder: match");
        else
            $display("bch_systematic_lfsr_encoder: mismatch");
        $finish;
    end

endmodule

@@ bch_systematic_lfsr_encoder.f @@
rtl/core/bch_pkg.sv
rtl/core/bch_if.sv
rtl/core/bch_cell.sv
rtl/core/bch_chain.sv
rtl/core/bch_systematic_lfsr_encoder.sv
verif/bch_checker.sv
verif/tb_top.sv
